[design/mpp_pkg.sv]
// ----------------------------------------------------------------------------
// mpp_pkg
// Shared types and codes for the magnitude percentile pruner.
// ----------------------------------------------------------------------------
`default_nettype none

package mpp_pkg;

    localparam int WEIGHT_BITS   = 16;
    localparam int COUNT_OUT_W   = 13;
    localparam int RATIO_W       = 16;
    localparam int DEF_STORE_DEPTH = 4096;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_SELECT   = 2'd1;
    localparam logic [1:0] ERR_EMPTY    = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    localparam logic [1:0] SEL_ZERO    = 2'd0;
    localparam logic [1:0] SEL_ONE     = 2'd1;
    localparam logic [1:0] SEL_TWO     = 2'd2;
    localparam logic [1:0] SEL_ILLEGAL = 2'd3;

    localparam logic [1:0] REG_ENABLE    = 2'd0;
    localparam logic [1:0] REG_RATIO_ZERO = 2'd1;
    localparam logic [1:0] REG_RATIO_ONE  = 2'd2;
    localparam logic [1:0] REG_RATIO_TWO  = 2'd3;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_DRAIN = 2'd2;

    typedef struct packed {
        logic                          mode;
        logic signed [WEIGHT_BITS-1:0] weight_in;
        logic                          load_last;
        logic                          prune_request;
        logic [1:0]                    ratio_select;
    } in_item_t;

    typedef struct packed {
        logic signed [WEIGHT_BITS-1:0] weight_out;
        logic                          pruned;
        logic [WEIGHT_BITS-1:0]        threshold;
        logic [COUNT_OUT_W-1:0]        prune_count;
        logic [1:0]                    error_code;
        logic                          last_out;
    } out_item_t;

    typedef struct packed {
        logic [1:0] kind;
        in_item_t   item;
    } cls_item_t;

    typedef struct packed {
        logic               prune_enable;
        logic [RATIO_W-1:0] ratio_zero;
        logic [RATIO_W-1:0] ratio_one;
        logic [RATIO_W-1:0] ratio_two;
    } cfg_t;

endpackage

`default_nettype wire

[design/mpp_front.sv]
// ----------------------------------------------------------------------------
// mpp_front
// Input queue: accepts items, tags each as load, close or drain.
// ----------------------------------------------------------------------------
`default_nettype none

module mpp_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire mpp_pkg::in_item_t item,
    output logic                   full,
    output logic                   head_valid,
    output mpp_pkg::cls_item_t     head,
    input  wire logic              head_pop
);

    mpp_pkg::cls_item_t q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;
    mpp_pkg::cls_item_t kind_item;

    always_comb
    begin
        kind_item.item = item;
        if (item.mode)
        begin
            kind_item.kind = mpp_pkg::KIND_DRAIN;
        end
        else if (item.load_last)
        begin
            kind_item.kind = mpp_pkg::KIND_CLOSE;
        end
        else
        begin
            kind_item.kind = mpp_pkg::KIND_LOAD;
        end
    end

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = q_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = head_pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= kind_item;
        end
    end

endmodule

`default_nettype wire

[design/mpp_back.sv]
// ----------------------------------------------------------------------------
// mpp_back
// Weight store, threshold search and drain engine with a result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mpp_back
#(
    parameter int STORE_DEPTH = mpp_pkg::DEF_STORE_DEPTH
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mpp_pkg::cfg_t      cfg,
    input  wire logic               head_valid,
    input  wire mpp_pkg::cls_item_t head,
    output logic                    head_pop,
    output logic                    empty,
    output mpp_pkg::out_item_t      result,
    input  wire logic               pop
);

    localparam int W  = mpp_pkg::WEIGHT_BITS;
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int BW = $clog2(W);
    localparam int RW = mpp_pkg::RATIO_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DRAIN = 2'd1;
    localparam logic [1:0] ST_RANK  = 2'd2;
    localparam logic [1:0] ST_SCAN  = 2'd3;

    logic signed [W-1:0] mem [STORE_DEPTH];
    logic signed [W-1:0] rdata_reg;
    logic [AW-1:0]       raddr;
    logic                we;
    logic [AW-1:0]       waddr;

    logic [1:0]    st_reg, st_next;
    logic [CW-1:0] size_reg, size_next;
    logic [CW-1:0] rp_reg, rp_next;
    logic [W-1:0]  cut_reg, cut_next;
    logic [CW-1:0] zeroed_reg, zeroed_next;
    logic          ready_reg, ready_next;
    logic [RW-1:0] ratio_reg, ratio_next;
    logic [1:0]    err_reg, err_next;
    logic [CW-1:0] rank_reg, rank_next;
    logic [CW-1:0] addr_reg, addr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          rdv_reg, rdv_next;
    logic [BW-1:0] bit_reg, bit_next;
    logic [W-1:0]  prefix_reg, prefix_next;
    logic          cpass_reg, cpass_next;

    mpp_pkg::out_item_t rq_reg [2];
    logic       rq_wr_reg, rq_rd_reg;
    logic [1:0] rq_cnt_reg;
    logic       rq_push, rq_pop;
    mpp_pkg::out_item_t rq_data;

    logic [CW-1:0]    s_eff;
    logic             ovf;
    logic [CW-1:0]    new_size;
    logic             active;
    logic [CW+RW-1:0] prod;
    logic [CW-1:0]    rank_raw;
    logic [W-1:0]     mag;
    logic [W-1:0]     cand;
    logic             hit;
    logic             issue;

    assign mag  = rdata_reg[W-1] ? W'(-rdata_reg) : W'(rdata_reg);
    assign cand = prefix_reg | ((W'(1) << bit_reg) - W'(1));
    assign hit  = cpass_reg ? (mag < prefix_reg) : (mag <= cand);
    assign prod = (CW+RW)'(size_reg) * (CW+RW)'(ratio_reg);
    assign rank_raw = prod[CW+RW-1:RW];

    always_comb
    begin
        st_next     = st_reg;
        size_next   = size_reg;
        rp_next     = rp_reg;
        cut_next    = cut_reg;
        zeroed_next = zeroed_reg;
        ready_next  = ready_reg;
        ratio_next  = ratio_reg;
        err_next    = err_reg;
        rank_next   = rank_reg;
        addr_next   = addr_reg;
        cnt_next    = cnt_reg;
        rdv_next    = 1'b0;
        bit_next    = bit_reg;
        prefix_next = prefix_reg;
        cpass_next  = cpass_reg;
        head_pop    = 1'b0;
        we          = 1'b0;
        rq_push     = 1'b0;
        rq_data     = '0;
        s_eff       = ready_reg ? '0 : size_reg;
        ovf         = (s_eff >= CW'(STORE_DEPTH));
        new_size    = ovf ? s_eff : s_eff + CW'(1);
        waddr       = s_eff[AW-1:0];
        active      = cfg.prune_enable && head.item.prune_request &&
                      (head.item.ratio_select != mpp_pkg::SEL_ILLEGAL);
        issue       = (addr_reg < size_reg);
        raddr       = (st_reg == ST_IDLE) ? rp_reg[AW-1:0] : addr_reg[AW-1:0];

        case (st_reg)
            ST_IDLE:
            begin
                if (head_valid && rq_cnt_reg != 2'd2)
                begin
                    head_pop = 1'b1;
                    if (head.kind == mpp_pkg::KIND_DRAIN)
                    begin
                        if (!ready_reg || rp_reg >= size_reg)
                        begin
                            rq_push             = 1'b1;
                            rq_data.threshold   = cut_reg;
                            rq_data.prune_count = mpp_pkg::COUNT_OUT_W'(zeroed_reg);
                            rq_data.error_code  = mpp_pkg::ERR_EMPTY;
                        end
                        else
                        begin
                            st_next = ST_DRAIN;
                        end
                    end
                    else
                    begin
                        we          = !ovf;
                        size_next   = new_size;
                        ready_next  = 1'b0;
                        rp_next     = '0;
                        if (ready_reg || head.kind == mpp_pkg::KIND_CLOSE)
                        begin
                            cut_next    = '0;
                            zeroed_next = '0;
                        end
                        if (head.kind == mpp_pkg::KIND_LOAD)
                        begin
                            if (ovf)
                            begin
                                rq_push            = 1'b1;
                                rq_data.error_code = mpp_pkg::ERR_OVERFLOW;
                            end
                        end
                        else
                        begin
                            if (ovf)
                            begin
                                err_next = mpp_pkg::ERR_OVERFLOW;
                            end
                            else if (cfg.prune_enable && head.item.prune_request &&
                                     head.item.ratio_select == mpp_pkg::SEL_ILLEGAL)
                            begin
                                err_next = mpp_pkg::ERR_SELECT;
                            end
                            else
                            begin
                                err_next = mpp_pkg::ERR_OK;
                            end
                            case (head.item.ratio_select)
                                mpp_pkg::SEL_ZERO: ratio_next = cfg.ratio_zero;
                                mpp_pkg::SEL_ONE:  ratio_next = cfg.ratio_one;
                                default:           ratio_next = cfg.ratio_two;
                            endcase
                            if (active)
                            begin
                                st_next = ST_RANK;
                            end
                            else
                            begin
                                ready_next         = 1'b1;
                                rq_push            = 1'b1;
                                rq_data.error_code = err_next;
                            end
                        end
                    end
                end
            end

            ST_DRAIN:
            begin
                rq_push             = 1'b1;
                rq_data.threshold   = cut_reg;
                rq_data.prune_count = mpp_pkg::COUNT_OUT_W'(zeroed_reg);
                rq_data.error_code  = mpp_pkg::ERR_OK;
                if (mag < cut_reg)
                begin
                    rq_data.pruned     = 1'b1;
                    rq_data.weight_out = '0;
                end
                else
                begin
                    rq_data.weight_out = rdata_reg;
                end
                rq_data.last_out = (rp_reg + CW'(1) == size_reg);
                if (rq_data.last_out)
                begin
                    ready_next = 1'b0;
                end
                rp_next = rp_reg + CW'(1);
                st_next = ST_IDLE;
            end

            ST_RANK:
            begin
                rank_next   = (rank_raw > size_reg - CW'(1)) ? size_reg - CW'(1) : rank_raw;
                addr_next   = '0;
                cnt_next    = '0;
                bit_next    = BW'(W - 1);
                prefix_next = '0;
                cpass_next  = 1'b0;
                st_next     = ST_SCAN;
            end

            ST_SCAN:
            begin
                rdv_next = issue;
                if (issue)
                begin
                    addr_next = addr_reg + CW'(1);
                end
                if (rdv_reg && hit)
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                if (!issue && !rdv_reg)
                begin
                    addr_next = '0;
                    cnt_next  = '0;
                    if (cpass_reg)
                    begin
                        cut_next           = prefix_reg;
                        zeroed_next        = cnt_reg;
                        ready_next         = 1'b1;
                        rq_push            = 1'b1;
                        rq_data.threshold  = prefix_reg;
                        rq_data.prune_count = mpp_pkg::COUNT_OUT_W'(cnt_reg);
                        rq_data.error_code = err_reg;
                        st_next            = ST_IDLE;
                    end
                    else
                    begin
                        if (!(cnt_reg > rank_reg))
                        begin
                            prefix_next = prefix_reg | (W'(1) << bit_reg);
                        end
                        if (bit_reg == '0)
                        begin
                            cpass_next = 1'b1;
                        end
                        else
                        begin
                            bit_next = bit_reg - BW'(1);
                        end
                    end
                end
            end

            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            size_reg   <= '0;
            rp_reg     <= '0;
            cut_reg    <= '0;
            zeroed_reg <= '0;
            ready_reg  <= 1'b0;
            rdv_reg    <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            size_reg   <= size_next;
            rp_reg     <= rp_next;
            cut_reg    <= cut_next;
            zeroed_reg <= zeroed_next;
            ready_reg  <= ready_next;
            rdv_reg    <= rdv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ratio_reg  <= ratio_next;
        err_reg    <= err_next;
        rank_reg   <= rank_next;
        addr_reg   <= addr_next;
        cnt_reg    <= cnt_next;
        bit_reg    <= bit_next;
        prefix_reg <= prefix_next;
        cpass_reg  <= cpass_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= head.item.weight_in;
        end
        rdata_reg <= mem[raddr];
    end

    // result queue
    assign empty  = (rq_cnt_reg == 2'd0);
    assign result = rq_reg[rq_rd_reg];
    assign rq_pop = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rq_wr_reg  <= 1'b0;
            rq_rd_reg  <= 1'b0;
            rq_cnt_reg <= 2'd0;
        end
        else
        begin
            if (rq_push)
            begin
                rq_wr_reg <= !rq_wr_reg;
            end
            if (rq_pop)
            begin
                rq_rd_reg <= !rq_rd_reg;
            end
            rq_cnt_reg <= rq_cnt_reg + 2'(rq_push) - 2'(rq_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rq_push)
        begin
            rq_reg[rq_wr_reg] <= rq_data;
        end
    end

endmodule

`default_nettype wire

[design/magnitude_percentile_pruner.sv]
// ----------------------------------------------------------------------------
// magnitude_percentile_pruner
// Magnitude pruning of a loaded weight set at a percentile threshold.
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  item      in         push / full            mpp_pkg::in_item_t
//  result    out        pop / empty            mpp_pkg::out_item_t
//  config    in         APB psel/penable/...   4 registers at 4*i
//
//  Drain item: registered store read, then its result from the DRAIN state.
//  Closing load with pruning: one bit-search counting pass over the store
//  per weight bit plus a final counting pass, one read a cycle.
//  Both queues are two deep; a full result queue stalls the engine only.
//  Reset clears control state; the store holds no reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module magnitude_percentile_pruner
#(
    parameter int STORE_DEPTH = mpp_pkg::DEF_STORE_DEPTH
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire mpp_pkg::in_item_t item,
    input  wire logic              pop,
    output logic                   empty,
    output mpp_pkg::out_item_t     result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    mpp_pkg::cfg_t      cfg_reg;
    logic               head_valid;
    mpp_pkg::cls_item_t head;
    logic               head_pop;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                mpp_pkg::REG_ENABLE:     cfg_reg.prune_enable <= pwdata[0];
                mpp_pkg::REG_RATIO_ZERO: cfg_reg.ratio_zero   <= pwdata[15:0];
                mpp_pkg::REG_RATIO_ONE:  cfg_reg.ratio_one    <= pwdata[15:0];
                default:                 cfg_reg.ratio_two    <= pwdata[15:0];
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            mpp_pkg::REG_ENABLE:     prdata = {31'd0, cfg_reg.prune_enable};
            mpp_pkg::REG_RATIO_ZERO: prdata = {16'd0, cfg_reg.ratio_zero};
            mpp_pkg::REG_RATIO_ONE:  prdata = {16'd0, cfg_reg.ratio_one};
            default:                 prdata = {16'd0, cfg_reg.ratio_two};
        endcase
    end

    mpp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .item       (item),
        .full       (full),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop)
    );

    mpp_back
    #(
        .STORE_DEPTH (STORE_DEPTH)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .head_pop   (head_pop),
        .empty      (empty),
        .result     (result),
        .pop        (pop)
    );

endmodule

`default_nettype wire
